// ===== src/tbpc_pkg.sv =====
package tbpc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned MsW   = 16;
  localparam int unsigned PortW = 8;

  // button positions in the expander byte, active low
  localparam logic [2:0] UP_BIT   = 3'd0;
  localparam logic [2:0] DOWN_BIT = 3'd4;

  localparam logic [MsW-1:0] HOLD_MS_RST     = 16'd1000;
  localparam logic [MsW-1:0] DEBOUNCE_MS_RST = 16'd50;

  typedef enum logic [1:0] {
    CFG_HOLD_MS          = 2'd0,
    CFG_DEBOUNCE_MS      = 2'd1,
    CFG_EXPANDER_PRESENT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_BOTH       = 3'd1,
    EV_SHORT_UP   = 3'd2,
    EV_LONG_UP    = 3'd3,
    EV_SHORT_DOWN = 3'd4,
    EV_LONG_DOWN  = 3'd5
  } event_e;

  typedef struct packed {
    logic [MsW-1:0] hold_ms;
    logic [MsW-1:0] debounce_ms;
    logic           expander_present;
  } cfg_t;

endpackage

// ===== src/tbpc_cfg_regs.sv =====
module tbpc_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [tbpc_pkg::MsW-1:0]  cfg_wdata_i,
  output tbpc_pkg::cfg_t            cfg_o
);

  tbpc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tbpc_pkg::CFG_HOLD_MS:          cfg_d.hold_ms = cfg_wdata_i;
        tbpc_pkg::CFG_DEBOUNCE_MS:      cfg_d.debounce_ms = cfg_wdata_i;
        tbpc_pkg::CFG_EXPANDER_PRESENT: cfg_d.expander_present = cfg_wdata_i[0];
        default:                        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_ms          <= tbpc_pkg::HOLD_MS_RST;
      cfg_q.debounce_ms      <= tbpc_pkg::DEBOUNCE_MS_RST;
      cfg_q.expander_present <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/tbpc_core.sv =====
module tbpc_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic [tbpc_pkg::TimeW-1:0]  time_ms_i,
  input  logic [tbpc_pkg::PortW-1:0]  port_byte_i,
  input  tbpc_pkg::cfg_t              cfg_i,
  output tbpc_pkg::event_e            code_o
);

  logic                       up_was_q, up_was_d;
  logic                       down_was_q, down_was_d;
  logic                       both_latch_q, both_latch_d;
  logic [tbpc_pkg::TimeW-1:0] up_start_q, up_start_d;
  logic [tbpc_pkg::TimeW-1:0] down_start_q, down_start_d;

  logic                       up, down;
  logic                       both_rel, latch_mid;
  logic                       up_ev, down_ev;
  logic [tbpc_pkg::TimeW-1:0] up_held, down_held;
  logic [tbpc_pkg::TimeW-1:0] deb_ext, hold_ext;

  assign up   = cfg_i.expander_present & ~port_byte_i[tbpc_pkg::UP_BIT];
  assign down = cfg_i.expander_present & ~port_byte_i[tbpc_pkg::DOWN_BIT];

  assign deb_ext  = {{(tbpc_pkg::TimeW-tbpc_pkg::MsW){1'b0}}, cfg_i.debounce_ms};
  assign hold_ext = {{(tbpc_pkg::TimeW-tbpc_pkg::MsW){1'b0}}, cfg_i.hold_ms};

  // a release only looks at the stored start, never at a same-poll edge
  assign up_held   = time_ms_i - up_start_q;
  assign down_held = time_ms_i - down_start_q;

  assign both_rel  = (~up | ~down) & up_was_q & down_was_q;
  assign latch_mid = both_latch_q | both_rel;
  assign up_ev     = ~up & up_was_q & ~down & ~latch_mid;
  assign down_ev   = ~down & down_was_q & ~up & ~latch_mid;

  always_comb begin
    code_o = tbpc_pkg::EV_NONE;
    if (both_rel) begin
      code_o = tbpc_pkg::EV_BOTH;
    end
    if (up_ev && (up_held > deb_ext)) begin
      code_o = (up_held < hold_ext) ? tbpc_pkg::EV_SHORT_UP : tbpc_pkg::EV_LONG_UP;
    end
    if (down_ev && (down_held > deb_ext)) begin
      code_o = (down_held < hold_ext) ? tbpc_pkg::EV_SHORT_DOWN : tbpc_pkg::EV_LONG_DOWN;
    end
  end

  always_comb begin
    up_was_d     = up_was_q;
    down_was_d   = down_was_q;
    both_latch_d = both_latch_q;
    up_start_d   = up_start_q;
    down_start_d = down_start_q;
    if (adv_i) begin
      up_was_d     = up;
      down_was_d   = down;
      both_latch_d = latch_mid & (up | down);
      if (up && !up_was_q) begin
        up_start_d = time_ms_i;
      end
      if (down && !down_was_q) begin
        down_start_d = time_ms_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_was_q     <= 1'b0;
      down_was_q   <= 1'b0;
      both_latch_q <= 1'b0;
      up_start_q   <= '0;
      down_start_q <= '0;
    end else begin
      up_was_q     <= up_was_d;
      down_was_q   <= down_was_d;
      both_latch_q <= both_latch_d;
      up_start_q   <= up_start_d;
      down_start_q <= down_start_d;
    end
  end

endmodule

// ===== src/two_button_press_classifier_unit.sv =====
// Two-button press classifier: every accepted poll (timestamp plus expander
// byte) yields exactly one event_code result, 0 when nothing is reported.
// A poll is taken into an input register, classified combinationally against the
// button state, and held in a result register; one poll can be accepted every
// cycle unless the input stalls, which it does only while both registers are
// full and the output is stalled.
// Configuration writes must be made while no poll is in flight.
module two_button_press_classifier_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [tbpc_pkg::MsW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tbpc_pkg::TimeW-1:0]  time_ms_i,
  input  logic [tbpc_pkg::PortW-1:0]  port_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  event_code_o
);

  tbpc_pkg::cfg_t             cfg;
  tbpc_pkg::event_e           code;

  logic                       s1_valid_q, s1_valid_d;
  logic [tbpc_pkg::TimeW-1:0] s1_time_q;
  logic [tbpc_pkg::PortW-1:0] s1_port_q;
  logic                       s2_valid_q, s2_valid_d;
  logic [2:0]                 s2_code_q;
  logic                       adv, in_acc;

  tbpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tbpc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .time_ms_i   (s1_time_q),
    .port_byte_i (s1_port_q),
    .cfg_i       (cfg),
    .code_o      (code)
  );

  // input stage moves on whenever the result register is free or draining
  assign adv        = s1_valid_q & (~s2_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & s2_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign s1_valid_d = in_acc | (s1_valid_q & ~adv);
  assign s2_valid_d = adv | (s2_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_time_q <= time_ms_i;
      s1_port_q <= port_byte_i;
    end
    if (adv) begin
      s2_code_q <= code;
    end
  end

  assign out_valid_o  = s2_valid_q;
  assign event_code_o = s2_code_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled while pipeline can drain");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid_q)
    else $error("accepted request lost from input stage");

  a_code_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_code_o <= tbpc_pkg::EV_LONG_DOWN))
    else $error("illegal event code");

  a_advance_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_o)
    else $error("classified request not held in result register");
`endif

endmodule
